/* src/tbpq_pkg.sv */
// shared types and constants for the tree bucket priority queue
`timescale 1ns / 1ps
`default_nettype none
package tbpq_pkg;

    localparam int PRI_W   = 31;
    localparam int PAY_W   = 32;
    localparam int LEAF_W  = 10;
    localparam int STAMP_W = 31;

    localparam logic [PRI_W-1:0] PRI_NONE = 31'h7FFF_FFFF;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [PAY_W-1:0]   pay;
        logic [LEAF_W-1:0]  leaf;
        logic [PRI_W-1:0]   pri;
    } elem_t;

    localparam elem_t ELEM_ZERO = '{stamp: '0, pay: '0, leaf: '0, pri: '0};
    localparam elem_t ELEM_NONE = '{stamp: '0, pay: '0, leaf: '0, pri: PRI_NONE};

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage
`default_nettype wire

/* src/tbpq_bucket_mem.sv */
// bucket slot memory and subtree minimum memory with clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none
module tbpq_bucket_mem #(
    parameter int SLOT_DEPTH = 8200,
    parameter int NODE_DEPTH = 2047
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire tbpq_pkg::mem_cmd_t                bkt_cmd,
    input  wire logic [$clog2(SLOT_DEPTH)-1:0]     bkt_addr,
    input  wire tbpq_pkg::elem_t                   bkt_wdata,
    output tbpq_pkg::elem_t                        bkt_rdata,
    input  wire tbpq_pkg::mem_cmd_t                min_cmd,
    input  wire logic [$clog2(NODE_DEPTH)-1:0]     min_addr,
    input  wire tbpq_pkg::elem_t                   min_wdata,
    output tbpq_pkg::elem_t                        min_rdata,
    output logic                                   init_done
);
    import tbpq_pkg::*;

    localparam int SAW = $clog2(SLOT_DEPTH);
    localparam int NAW = $clog2(NODE_DEPTH);

    elem_t bkt_mem [SLOT_DEPTH];
    elem_t min_mem [NODE_DEPTH];

    logic [SAW-1:0] clr_reg;
    logic           done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end else if (!done_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == SAW'(SLOT_DEPTH - 1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    assign init_done = done_reg;

    always_ff @(posedge aclk) begin
        if (!done_reg) begin
            bkt_mem[clr_reg] <= ELEM_ZERO;
        end else if (bkt_cmd.wr) begin
            bkt_mem[bkt_addr] <= bkt_wdata;
        end
        if (bkt_cmd.rd) begin
            bkt_rdata <= bkt_mem[bkt_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!done_reg) begin
            if (clr_reg < SAW'(NODE_DEPTH)) begin
                min_mem[clr_reg[NAW-1:0]] <= ELEM_NONE;
            end
        end else if (min_cmd.wr) begin
            min_mem[min_addr] <= min_wdata;
        end
        if (min_cmd.rd) begin
            min_rdata <= min_mem[min_addr];
        end
    end

endmodule
`default_nettype wire

/* src/tbpq_work_mem.sv */
// working buffer memory for elements taken off a path
`timescale 1ns / 1ps
`default_nettype none
module tbpq_work_mem #(
    parameter int DEPTH = 97
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire tbpq_pkg::elem_t              wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output tbpq_pkg::elem_t                   rd_data
);
    import tbpq_pkg::*;

    elem_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/tree_bucket_priority_queue.sv */
// top level: sequencer for path read, greedy eviction and subtree minimum update
//
// s_ channel: one item per operation; s_tuser selects insert or extract-minimum.
// m_ channel: exactly one result item per accepted item.
// after reset a clearing pass sweeps the bucket memory, one slot per cycle
// (ROOT_SLOTS + (2*LEAVES-2)*BUCKET_SLOTS slots, 8200 at the defaults);
// s_tready stays low until it ends.
// an item is worked on alone; s_tready is low until its result is loaded.
// insert: reads every slot on both leaf paths into the working buffer, then per
// path node scans the buffer, reads the child minima and clears the free slots;
// extract: the same on one path; an empty extract skips the path.
// the result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds its last state until m_tready frees the register.
// ties among equal priorities go to the left child, then right, then slot order.
`timescale 1ns / 1ps
`default_nettype none
module tree_bucket_priority_queue #(
    parameter int LEAVES       = 1024,
    parameter int BUCKET_SLOTS = 4,
    parameter int ROOT_SLOTS   = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // priority_req, payload, target_leaf, rand_left_leaf, rand_right_leaf, zero fill
    input  wire logic [95:0]  s_tdata,
    // mode
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_priority, out_payload, out_leaf, out_stamp
    output logic [103:0]      m_tdata,
    // queue_empty, evict_overflow
    output logic [1:0]        m_tuser
);
    import tbpq_pkg::*;

    localparam int D        = $clog2(LEAVES);
    localparam int NODES    = 2 * LEAVES - 1;
    localparam int SLOTS    = ROOT_SLOTS + (NODES - 1) * BUCKET_SLOTS;
    localparam int WD       = ROOT_SLOTS + 34 * BUCKET_SLOTS + 1;
    localparam int SAW      = $clog2(SLOTS);
    localparam int NAW      = $clog2(NODES);
    localparam int WAW      = $clog2(WD);
    localparam int CNT_W    = $clog2(WD + 1);
    localparam int MAXCAP   = (ROOT_SLOTS > BUCKET_SLOTS) ? ROOT_SLOTS : BUCKET_SLOTS;
    localparam int CAP_W    = $clog2(MAXCAP + 1);
    localparam int IDX_W    = $clog2(2 * D + 1);
    localparam int LVL_W    = $clog2(D + 1);
    localparam logic [D-1:0] HALF_MASK = D'(LEAVES / 2 - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EX_RD, S_EX_CHK, S_RD_ISSUE, S_RD_TAKE, S_APPEND,
        S_EV_START, S_EV_SCAN, S_EV_ML, S_EV_MR, S_EV_MC, S_EV_MW, S_EV_CLR, S_DONE
    } state_t;

    function automatic logic [D-1:0] fit_leaf(input logic [15:0] v);
        logic [D-1:0] r;
        for (int b = 0; b < D; b++) begin
            r[b] = v[b];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic               mode_reg, mode_next;
    elem_t              new_reg, new_next;
    logic [D-1:0]       leaf_a_reg, leaf_a_next, leaf_b_reg, leaf_b_next;
    elem_t              exm_reg, exm_next;
    logic               empty_reg, empty_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CAP_W-1:0]   slot_reg, slot_next;
    logic [CAP_W-1:0]   taken_reg, taken_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rptr_reg, rptr_next, wptr_reg, wptr_next;
    logic               pv_reg, pv_next;
    elem_t              smin_reg, smin_next, cmin_reg, cmin_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               m_valid_reg, m_valid_next;
    elem_t              out_reg, out_next;
    logic               oempty_reg, oempty_next, ovf_reg, ovf_next;

    mem_cmd_t         bkt_cmd, min_cmd;
    logic [SAW-1:0]   bkt_addr;
    logic [NAW-1:0]   min_addr;
    elem_t            bkt_wdata, bkt_rdata, min_wdata, min_rdata;
    logic             init_done;
    logic             wk_wr, wk_rd;
    logic [WAW-1:0]   wk_waddr, wk_raddr;
    elem_t            wk_wdata, wk_rdata;

    tbpq_bucket_mem #(.SLOT_DEPTH(SLOTS), .NODE_DEPTH(NODES)) u_bucket (
        .aclk(aclk), .aresetn(aresetn),
        .bkt_cmd(bkt_cmd), .bkt_addr(bkt_addr), .bkt_wdata(bkt_wdata), .bkt_rdata(bkt_rdata),
        .min_cmd(min_cmd), .min_addr(min_addr), .min_wdata(min_wdata), .min_rdata(min_rdata),
        .init_done(init_done)
    );

    tbpq_work_mem #(.DEPTH(WD)) u_work (
        .aclk(aclk), .wr_en(wk_wr), .wr_addr(wk_waddr), .wr_data(wk_wdata),
        .rd_en(wk_rd), .rd_addr(wk_raddr), .rd_data(wk_rdata)
    );

    // current path node
    logic [IDX_W-1:0] last_idx, up;
    logic [LVL_W-1:0] lvl;
    logic [D-1:0]     leaf_sel, pos;
    logic [NAW-1:0]   node;
    logic [SAW-1:0]   base;
    logic [CAP_W-1:0] cap;
    logic             has_child;
    logic             under;
    logic             keep;
    elem_t            best;

    always_comb begin
        last_idx  = (mode_reg == MODE_INSERT) ? IDX_W'(2 * D) : IDX_W'(D);
        up        = (mode_reg == MODE_INSERT) ? (idx_reg >> 1) : idx_reg;
        lvl       = LVL_W'(D) - LVL_W'(up);
        leaf_sel  = (mode_reg == MODE_EXTRACT) ? fit_leaf(16'(exm_reg.leaf)) :
                    (idx_reg[0] ? leaf_b_reg : leaf_a_reg);
        pos       = leaf_sel >> up;
        node      = (NAW'(1) << lvl) - NAW'(1) + NAW'(pos);
        base      = (node == '0) ? '0 :
                    SAW'(ROOT_SLOTS) + SAW'(node - NAW'(1)) * SAW'(BUCKET_SLOTS);
        cap       = (node == '0) ? CAP_W'(ROOT_SLOTS) : CAP_W'(BUCKET_SLOTS);
        has_child = (up != '0);
        under     = ((fit_leaf(16'(wk_rdata.leaf)) >> up) == pos);
        keep      = (bkt_rdata.pri != '0) && (cnt_reg < CNT_W'(WD)) &&
                    !((mode_reg == MODE_EXTRACT) && (bkt_rdata.stamp == exm_reg.stamp));
        best      = (smin_reg.pri < cmin_reg.pri) ? smin_reg : cmin_reg;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        new_next     = new_reg;
        leaf_a_next  = leaf_a_reg;
        leaf_b_next  = leaf_b_reg;
        exm_next     = exm_reg;
        empty_next   = empty_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        taken_next   = taken_reg;
        cnt_next     = cnt_reg;
        rptr_next    = rptr_reg;
        wptr_next    = wptr_reg;
        pv_next      = pv_reg;
        smin_next    = smin_reg;
        cmin_next    = cmin_reg;
        stamp_next   = stamp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_next     = out_reg;
        oempty_next  = oempty_reg;
        ovf_next     = ovf_reg;
        bkt_cmd      = '0;
        bkt_addr     = base + SAW'(slot_reg);
        bkt_wdata    = ELEM_ZERO;
        min_cmd      = '0;
        min_addr     = '0;
        min_wdata    = best;
        wk_wr        = 1'b0;
        wk_waddr     = cnt_reg[WAW-1:0];
        wk_wdata     = bkt_rdata;
        wk_rd        = 1'b0;
        wk_raddr     = rptr_reg[WAW-1:0];

        unique case (state_reg)
            S_INIT: begin
                if (init_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = s_tuser;
                    new_next    = '{stamp: stamp_reg, pay: s_tdata[62:31],
                                    leaf: s_tdata[72:63] & LEAF_W'(LEAVES - 1),
                                    pri: s_tdata[30:0]};
                    leaf_a_next = fit_leaf(16'(s_tdata[81:73])) & HALF_MASK;
                    leaf_b_next = (fit_leaf(16'(s_tdata[90:82])) & HALF_MASK) | ~HALF_MASK;
                    empty_next  = 1'b0;
                    idx_next    = '0;
                    slot_next   = '0;
                    cnt_next    = '0;
                    state_next  = (s_tuser == MODE_INSERT) ? S_RD_ISSUE : S_EX_RD;
                end
            end
            S_EX_RD: begin
                min_cmd.rd = 1'b1;
                state_next = S_EX_CHK;
            end
            S_EX_CHK: begin
                exm_next = min_rdata;
                if (min_rdata.pri == PRI_NONE || min_rdata.pri == '0) begin
                    empty_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD_ISSUE;
                end
            end
            S_RD_ISSUE: begin
                bkt_cmd.rd = 1'b1;
                state_next = S_RD_TAKE;
            end
            S_RD_TAKE: begin
                if (keep) begin
                    wk_wr    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = S_RD_ISSUE;
                if (slot_reg == cap - 1'b1) begin
                    slot_next = '0;
                    if (idx_reg == last_idx) begin
                        idx_next   = '0;
                        state_next = (mode_reg == MODE_INSERT) ? S_APPEND : S_EV_START;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_APPEND: begin
                wk_wdata = new_reg;
                if (new_reg.pri != '0 && cnt_reg < CNT_W'(WD)) begin
                    wk_wr    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                stamp_next = stamp_reg + 1'b1;
                state_next = S_EV_START;
            end
            S_EV_START: begin
                rptr_next  = '0;
                wptr_next  = '0;
                taken_next = '0;
                pv_next    = 1'b0;
                smin_next  = ELEM_NONE;
                cmin_next  = ELEM_NONE;
                state_next = S_EV_SCAN;
            end
            S_EV_SCAN: begin
                pv_next = (rptr_reg < cnt_reg);
                if (rptr_reg < cnt_reg) begin
                    wk_rd     = 1'b1;
                    rptr_next = rptr_reg + 1'b1;
                end
                if (pv_reg) begin
                    if (taken_reg < cap && under) begin
                        bkt_cmd.wr = 1'b1;
                        bkt_addr   = base + SAW'(taken_reg);
                        bkt_wdata  = wk_rdata;
                        taken_next = taken_reg + 1'b1;
                        if (wk_rdata.pri != '0 && wk_rdata.pri < smin_reg.pri) begin
                            smin_next = wk_rdata;
                        end
                    end else begin
                        wk_wr     = 1'b1;
                        wk_waddr  = wptr_reg[WAW-1:0];
                        wk_wdata  = wk_rdata;
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
                if (!(rptr_reg < cnt_reg) && !pv_reg) begin
                    cnt_next   = wptr_reg;
                    state_next = has_child ? S_EV_ML : S_EV_MW;
                end
            end
            S_EV_ML: begin
                min_cmd.rd = 1'b1;
                min_addr   = NAW'({node, 1'b1});
                state_next = S_EV_MR;
            end
            S_EV_MR: begin
                min_cmd.rd = 1'b1;
                min_addr   = NAW'({node, 1'b1}) + NAW'(1);
                if (min_rdata.pri != '0 && min_rdata.pri < cmin_reg.pri) begin
                    cmin_next = min_rdata;
                end
                state_next = S_EV_MC;
            end
            S_EV_MC: begin
                if (min_rdata.pri != '0 && min_rdata.pri < cmin_reg.pri) begin
                    cmin_next = min_rdata;
                end
                state_next = S_EV_MW;
            end
            S_EV_MW: begin
                min_cmd.wr = 1'b1;
                min_addr   = node;
                slot_next  = taken_reg;
                state_next = S_EV_CLR;
            end
            S_EV_CLR: begin
                if (slot_reg < cap) begin
                    bkt_cmd.wr = 1'b1;
                    slot_next  = slot_reg + 1'b1;
                end else begin
                    slot_next = '0;
                    if (idx_reg == last_idx) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EV_START;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_next     = (mode_reg == MODE_INSERT || empty_reg) ? ELEM_ZERO : exm_reg;
                    oempty_next  = empty_reg;
                    ovf_next     = (cnt_reg != '0);
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            stamp_reg   <= STAMP_W'(1);
            pv_reg      <= 1'b0;
            empty_reg   <= 1'b0;
            mode_reg    <= MODE_INSERT;
            idx_reg     <= '0;
            slot_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            stamp_reg   <= stamp_next;
            pv_reg      <= pv_next;
            empty_reg   <= empty_next;
            mode_reg    <= mode_next;
            idx_reg     <= idx_next;
            slot_reg    <= slot_next;
        end
        new_reg    <= new_next;
        leaf_a_reg <= leaf_a_next;
        leaf_b_reg <= leaf_b_next;
        exm_reg    <= exm_next;
        taken_reg  <= taken_next;
        rptr_reg   <= rptr_next;
        wptr_reg   <= wptr_next;
        smin_reg   <= smin_next;
        cmin_reg   <= cmin_next;
        out_reg    <= out_next;
        oempty_reg <= oempty_next;
        ovf_reg    <= ovf_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.stamp, out_reg.leaf, out_reg.pay, out_reg.pri};
    assign m_tuser  = {ovf_reg, oempty_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(WD))
        else $error("working buffer count beyond depth");

    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_tready)
        else $error("ready during clearing pass");

    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EV_SCAN |-> taken_reg <= cap)
        else $error("bucket overfilled during eviction");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule
`default_nettype wire
